// ===== hw/rtl/fptw_pkg.sv =====
// Package for the four-level page table walker.
// Holds item and result structs, field widths and code constants.
// No dependencies.
`default_nettype none

package fptw_pkg;

  localparam int unsigned VaWidth   = 48;
  localparam int unsigned AddrWidth = 52;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned IdxWidth  = 9;
  localparam int unsigned LargeBit  = 7;

  // Input item kinds
  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_REPLY     = 1'b1;

  // Result kinds
  localparam logic RES_REQUEST = 1'b0;
  localparam logic RES_DONE    = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_4K       = 2'd0;
  localparam logic [1:0] ST_1G       = 2'd1;
  localparam logic [1:0] ST_2M       = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  // Walk levels: which table the pending read targets
  localparam logic [1:0] LVL_ROOT    = 2'd0;
  localparam logic [1:0] LVL_DIR_PTR = 2'd1;
  localparam logic [1:0] LVL_DIR     = 2'd2;
  localparam logic [1:0] LVL_TABLE   = 2'd3;

  typedef struct packed {
    logic                 kind;
    logic [VaWidth-1:0]   virt_addr;
    logic [DataWidth-1:0] read_data;
  } item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [AddrWidth-1:0] mem_addr;
    logic [AddrWidth-1:0] result_addr;
    logic [1:0]           result_status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fptw_in_reg.sv =====
// Input register of the page table walker: holds one accepted item.
// Depends on fptw_pkg.
`default_nettype none

module fptw_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire fptw_pkg::item_t item_i,
  input  wire logic            advance_i,
  output logic                 valid_o,
  output fptw_pkg::item_t      item_o
);
  import fptw_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Take a new item when empty or when the held one moves on
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fptw_walk.sv =====
// Walk state and step logic: root pointer, walk level, held address.
// Turns one item into at most one result. Depends on fptw_pkg.
`default_nettype none

module fptw_walk #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fptw_pkg::AddrWidth-1:0] cfg_data_i,
  input  wire logic                           fire_i,
  input  wire fptw_pkg::item_t                item_i,
  output logic                                produce_o,
  output fptw_pkg::result_t                   result_o
);
  import fptw_pkg::*;

  localparam int unsigned PaW = PHYS_ADDR_BITS;

  logic [AddrWidth-1:0] table_base_q;
  logic                 busy_q, busy_d;
  logic [1:0]           level_q, level_d;
  logic [VaWidth-1:0]   vaddr_q, vaddr_d;
  logic [PaW-1:0]       entry_addr_q, entry_addr_d;

  logic [DataWidth-1:0] entry;
  logic [PaW-1:0]       root_addr;
  logic [PaW-1:0]       gig_addr;
  logic [PaW-1:0]       meg_addr;

  assign entry = item_i.read_data;

  // Root entry address: real add, base is arbitrary
  assign root_addr = table_base_q[PaW-1:0]
                   + PaW'({item_i.virt_addr[47:39], 3'b000});

  // Large page addresses: frame and offset bits are disjoint
  assign gig_addr = {entry[PaW-1:30], vaddr_q[29:0]};
  assign meg_addr = {entry[PaW-1:21], vaddr_q[20:0]};

  always_comb begin
    logic           do_req;
    logic           do_done;
    logic [PaW-1:0] req_addr;
    logic [PaW-1:0] done_addr;
    logic [1:0]     done_status;

    do_req       = 1'b0;
    do_done      = 1'b0;
    req_addr     = '0;
    done_addr    = '0;
    done_status  = ST_UNMAPPED;
    busy_d       = busy_q;
    level_d      = level_q;
    vaddr_d      = vaddr_q;
    entry_addr_d = entry_addr_q;

    if (item_i.kind == KIND_TRANSLATE) begin
      // Start a walk unless one is running
      if (!busy_q) begin
        vaddr_d  = item_i.virt_addr;
        busy_d   = 1'b1;
        level_d  = LVL_ROOT;
        do_req   = 1'b1;
        req_addr = root_addr;
      end
    end else if (busy_q) begin
      if (entry == '0) begin
        do_done     = 1'b1;
        done_status = ST_UNMAPPED;
      end else begin
        case (level_q)
          LVL_ROOT: begin
            level_d  = LVL_DIR_PTR;
            do_req   = 1'b1;
            req_addr = {entry[PaW-1:12], vaddr_q[38:30], 3'b000};
          end
          LVL_DIR_PTR: begin
            if (entry[LargeBit]) begin
              do_done     = 1'b1;
              done_addr   = gig_addr;
              done_status = ST_1G;
            end else begin
              level_d  = LVL_DIR;
              do_req   = 1'b1;
              req_addr = {entry[PaW-1:12], vaddr_q[29:21], 3'b000};
            end
          end
          LVL_DIR: begin
            if (entry[LargeBit]) begin
              do_done     = 1'b1;
              done_addr   = meg_addr;
              done_status = ST_2M;
            end else begin
              level_d  = LVL_TABLE;
              do_req   = 1'b1;
              req_addr = {entry[PaW-1:12], vaddr_q[20:12], 3'b000};
            end
          end
          default: begin
            do_done     = 1'b1;
            done_addr   = entry_addr_q;
            done_status = ST_4K;
          end
        endcase
      end
    end

    // Build the result item
    result_o = '0;
    if (do_req) begin
      entry_addr_d         = req_addr;
      result_o.result_kind = RES_REQUEST;
      result_o.mem_addr    = AddrWidth'(req_addr);
    end else if (do_done) begin
      busy_d                 = 1'b0;
      level_d                = LVL_ROOT;
      result_o.result_kind   = RES_DONE;
      result_o.result_addr   = AddrWidth'(done_addr);
      result_o.result_status = done_status;
    end
    produce_o = do_req || do_done;
  end

  // Control state and root pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
      busy_q       <= 1'b0;
      level_q      <= LVL_ROOT;
    end else begin
      if (cfg_we_i) begin
        table_base_q <= cfg_data_i;
      end
      if (fire_i) begin
        busy_q  <= busy_d;
        level_q <= level_d;
      end
    end
  end

  // Held walk payload
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      vaddr_q      <= vaddr_d;
      entry_addr_q <= entry_addr_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fptw_out_reg.sv =====
// Output register of the page table walker: holds one result item.
// Depends on fptw_pkg.
`default_nettype none

module fptw_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire fptw_pkg::result_t result_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fptw_pkg::result_t      result_o
);
  import fptw_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_table_walker.sv =====
// Four-level page table walker (4 KiB granule, 48-bit virtual addresses).
// A translate item starts a walk; the walker answers with a read request for the
// top-level entry, and each reply item (one 8-byte entry) yields either the next
// read request or a finished result: the final 4 KiB entry address, a 1 GiB or
// 2 MiB page address, or not mapped. A translate during a walk and a reply with
// no walk running are dropped without a result. Throughput is one item per
// cycle when out_ready_i holds no result back; each item waits in the input
// register and its result is registered in the output register as it moves on.
// The walk state updates in the single step between those two registers, which
// sets the one-item-per-cycle figure. table_base is written through the cfg
// port, which is always ready; write it only while no walk is in progress.
// Depends on fptw_pkg, fptw_in_reg, fptw_walk and fptw_out_reg.
`default_nettype none

module four_level_page_table_walker #(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fptw_pkg::AddrWidth-1:0] table_base_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           kind_i,
  input  wire logic [fptw_pkg::VaWidth-1:0]   virt_addr_i,
  input  wire logic [fptw_pkg::DataWidth-1:0] read_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                result_kind_o,
  output logic [fptw_pkg::AddrWidth-1:0]      mem_addr_o,
  output logic [fptw_pkg::AddrWidth-1:0]      result_addr_o,
  output logic [1:0]                          result_status_o
);
  import fptw_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    produce;
  logic    out_free;
  result_t step_result;
  result_t out_result;

  assign cfg_ready_o = 1'b1;

  assign in_item.kind      = kind_i;
  assign in_item.virt_addr = virt_addr_i;
  assign in_item.read_data = read_data_i;

  // Move the held item on when the output slot can take its result
  assign advance = held_valid && out_free;

  fptw_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  fptw_walk #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (table_base_i),
    .fire_i     (advance),
    .item_i     (held_item),
    .produce_o  (produce),
    .result_o   (step_result)
  );

  fptw_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && produce),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign result_kind_o   = out_result.result_kind;
  assign mem_addr_o      = out_result.mem_addr;
  assign result_addr_o   = out_result.result_addr;
  assign result_status_o = out_result.result_status;

endmodule

`default_nettype wire
